/* hdl/diac_pkg.sv */
// ----------------------------------------------------------------------------
// diac_pkg
// Types and constants shared by the door intrusion alarm controller files.
// ----------------------------------------------------------------------------
package diac_pkg;

	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_SENSOR_EN   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_SOUND_EN    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_ALARM_DUR   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_LEFT_OPEN   = 3'd4;

	localparam logic [1:0] TONE_SILENT = 2'd0;
	localparam logic [1:0] TONE_LOW    = 2'd1;
	localparam logic [1:0] TONE_HIGH   = 2'd2;

	localparam logic [8:0] TONE_GAP  = 9'd300;
	localparam logic [7:0] BLINK_GAP = 8'd200;

	localparam logic [7:0]  DEBOUNCE_RST   = 8'd50;
	localparam logic [19:0] ALARM_DUR_RST  = 20'd60000;
	localparam logic [19:0] LEFT_OPEN_RST  = 20'd10000;

	typedef struct packed {
		logic door_raw;
		logic lock_unlocked;
		logic acknowledge;
	} item_t;

	typedef struct packed {
		logic [1:0] buzzer_tone;
		logic       red_led;
		logic       door_open;
		logic       alarm_active;
		logic       left_open_active;
		logic       evt_opened;
		logic       evt_closed;
		logic       evt_tamper;
		logic       evt_alarm_cleared;
	} result_t;

endpackage

/* hdl/door_intrusion_alarm_controller_core.sv */
// ----------------------------------------------------------------------------
// door_intrusion_alarm_controller_core
// Debounced door contact, tamper and left-open alarms, buzzer and LED drive.
// ----------------------------------------------------------------------------
// Usage:
// Each word on the item channel is one millisecond tick holding the raw door
// contact, the lock state and the dashboard acknowledge. Every accepted word
// produces exactly one word on the result channel.
// A word is accepted when item_valid is high and item_stall is low; a result
// is taken when result_valid is high and result_stall is low.
// The result of a word taken at one edge is loaded at that edge, into the
// result register or, while that is full and not taken, the skid register.
// Throughput is one word per cycle while result_stall is low, set by the
// single state update between the accepting edge and the result register.
// A skid register sits behind the result register, so one more word is taken
// while the result channel stalls; item_stall rises only once both are full.
// Reset clears all alarm state, loads the register defaults, sets the red LED
// level high and empties both result slots.
// Registers (APB, byte address 4*i): sensor_enable, sound_enable,
// debounce_ms, alarm_duration_ms, left_open_warn_ms. Write them only while
// no word is in flight.
// ----------------------------------------------------------------------------
module door_intrusion_alarm_controller_core #(
	parameter int unsigned TIME_BITS = 20
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  diac_pkg::item_t               item,
	output logic                          result_valid,
	input  logic                          result_stall,
	output diac_pkg::result_t             result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [diac_pkg::ADDR_W-1:0]   paddr,
	input  logic [diac_pkg::DATA_W-1:0]   pwdata,
	output logic [diac_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	localparam int unsigned CW = (TIME_BITS > 20) ? TIME_BITS : 20;
	localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

	logic        sensor_en_q, sound_en_q;
	logic [7:0]  debounce_q;
	logic [19:0] alarm_dur_q, left_open_q;

	logic                 door_q, door_d;
	logic [7:0]           stable_q, stable_d;
	logic                 boot_q, boot_d;
	logic                 alarm_q, alarm_d;
	logic [TIME_BITS-1:0] alarm_el_q, alarm_el_d;
	logic                 auth_q, auth_d;
	logic [TIME_BITS-1:0] open_el_q, open_el_d;
	logic                 left_q, left_d;
	logic [8:0]           tone_el_q, tone_el_d;
	logic                 tone_hi_q, tone_hi_d;
	logic [1:0]           tone_q, tone_d;
	logic [7:0]           blink_el_q, blink_el_d;
	logic                 blink_q, blink_d;
	logic                 red_q, red_d;
	logic                 ev_open, ev_close, ev_tamper, ev_clear;

	logic                 out_vld_q, skid_vld_q;
	diac_pkg::result_t    out_q, skid_q, res_d;
	logic                 accept, take, out_free;
	logic [diac_pkg::REG_IDX_W-1:0] reg_idx;
	logic                 cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[diac_pkg::ADDR_W-1:2];
	assign cfg_wr  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_en_q <= 1'b1;
			sound_en_q  <= 1'b1;
			debounce_q  <= diac_pkg::DEBOUNCE_RST;
			alarm_dur_q <= diac_pkg::ALARM_DUR_RST;
			left_open_q <= diac_pkg::LEFT_OPEN_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				diac_pkg::REG_SENSOR_EN: sensor_en_q <= pwdata[0];
				diac_pkg::REG_SOUND_EN:  sound_en_q  <= pwdata[0];
				diac_pkg::REG_DEBOUNCE:  debounce_q  <= pwdata[7:0];
				diac_pkg::REG_ALARM_DUR: alarm_dur_q <= pwdata[19:0];
				diac_pkg::REG_LEFT_OPEN: left_open_q <= pwdata[19:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			diac_pkg::REG_SENSOR_EN: prdata = {31'd0, sensor_en_q};
			diac_pkg::REG_SOUND_EN:  prdata = {31'd0, sound_en_q};
			diac_pkg::REG_DEBOUNCE:  prdata = {24'd0, debounce_q};
			diac_pkg::REG_ALARM_DUR: prdata = {12'd0, alarm_dur_q};
			diac_pkg::REG_LEFT_OPEN: prdata = {12'd0, left_open_q};
			default:                 prdata = '0;
		endcase
	end

	always_comb begin
		door_d     = door_q;
		stable_d   = stable_q;
		boot_d     = boot_q;
		alarm_d    = alarm_q;
		alarm_el_d = alarm_el_q;
		auth_d     = auth_q;
		open_el_d  = open_el_q;
		left_d     = left_q;
		tone_el_d  = tone_el_q;
		tone_hi_d  = tone_hi_q;
		tone_d     = tone_q;
		blink_el_d = blink_el_q;
		blink_d    = blink_q;
		red_d      = red_q;
		ev_open    = 1'b0;
		ev_close   = 1'b0;
		ev_tamper  = 1'b0;
		ev_clear   = 1'b0;

		// advance saturating timers
		if (tone_el_q <= diac_pkg::TONE_GAP) tone_el_d = tone_el_q + 9'd1;
		if (blink_el_q <= diac_pkg::BLINK_GAP) blink_el_d = blink_el_q + 8'd1;
		if (alarm_q && alarm_el_q != TMAX) alarm_el_d = alarm_el_q + 1'b1;
		if (auth_q && open_el_q != TMAX) open_el_d = open_el_q + 1'b1;

		if (item.acknowledge && alarm_d) begin
			alarm_d    = 1'b0;
			alarm_el_d = '0;
			tone_d     = diac_pkg::TONE_SILENT;
			red_d      = 1'b1;
		end

		if (sensor_en_q) begin
			if (!boot_q && item.door_raw) begin
				boot_d   = 1'b1;
				door_d   = 1'b1;
				stable_d = '0;
				if (!alarm_d) begin
					alarm_d    = 1'b1;
					alarm_el_d = '0;
					ev_tamper  = 1'b1;
				end
				ev_open = 1'b1;
			end else begin
				boot_d = 1'b1;
				if (item.door_raw == door_q) begin
					stable_d = '0;
				end else if (stable_q >= debounce_q) begin
					stable_d = '0;
					door_d   = item.door_raw;
					if (item.door_raw) begin
						if (item.lock_unlocked) begin
							auth_d    = 1'b1;
							open_el_d = '0;
							left_d    = 1'b0;
						end else if (!alarm_d) begin
							alarm_d    = 1'b1;
							alarm_el_d = '0;
							ev_tamper  = 1'b1;
						end
						ev_open = 1'b1;
					end else begin
						auth_d    = 1'b0;
						open_el_d = '0;
						if (left_q) begin
							left_d = 1'b0;
							tone_d = diac_pkg::TONE_SILENT;
						end
						ev_close = 1'b1;
					end
				end else begin
					stable_d = stable_q + 8'd1;
				end
			end
		end else begin
			stable_d = '0;
		end

		if (alarm_d) begin
			if (sound_en_q && tone_el_d > diac_pkg::TONE_GAP) begin
				tone_hi_d = ~tone_hi_d;
				tone_d    = tone_hi_d ? diac_pkg::TONE_HIGH : diac_pkg::TONE_LOW;
				tone_el_d = '0;
			end
			if (blink_el_d > diac_pkg::BLINK_GAP) begin
				blink_d    = ~blink_q;
				red_d      = ~blink_q;
				blink_el_d = '0;
			end
			if (CW'(alarm_el_d) > CW'(alarm_dur_q)) begin
				alarm_d    = 1'b0;
				alarm_el_d = '0;
				tone_d     = diac_pkg::TONE_SILENT;
				red_d      = 1'b1;
				if (!door_d) ev_clear = 1'b1;
			end
		end

		if (auth_d && door_d && !alarm_d) begin
			if (CW'(open_el_d) >= CW'(left_open_q)) begin
				if (!left_d) begin
					left_d    = 1'b1;
					ev_tamper = 1'b1;
				end
				if (sound_en_q && tone_el_d > diac_pkg::TONE_GAP) begin
					tone_hi_d = ~tone_hi_d;
					tone_d    = tone_hi_d ? diac_pkg::TONE_HIGH : diac_pkg::TONE_LOW;
					tone_el_d = '0;
				end
			end
		end

		res_d.buzzer_tone       = tone_d;
		res_d.red_led           = red_d;
		res_d.door_open         = door_d;
		res_d.alarm_active      = alarm_d;
		res_d.left_open_active  = left_d;
		res_d.evt_opened        = ev_open;
		res_d.evt_closed        = ev_close;
		res_d.evt_tamper        = ev_tamper;
		res_d.evt_alarm_cleared = ev_clear;
	end

	assign item_stall   = skid_vld_q;
	assign accept       = item_valid & ~item_stall;
	assign take         = out_vld_q & ~result_stall;
	assign out_free     = ~out_vld_q | take;
	assign result_valid = out_vld_q;
	assign result       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			door_q     <= 1'b0;
			stable_q   <= '0;
			boot_q     <= 1'b0;
			alarm_q    <= 1'b0;
			alarm_el_q <= '0;
			auth_q     <= 1'b0;
			open_el_q  <= '0;
			left_q     <= 1'b0;
			tone_el_q  <= diac_pkg::TONE_GAP + 9'd1;
			tone_hi_q  <= 1'b0;
			tone_q     <= diac_pkg::TONE_SILENT;
			blink_el_q <= diac_pkg::BLINK_GAP + 8'd1;
			blink_q    <= 1'b0;
			red_q      <= 1'b1;
		end else if (accept) begin
			door_q     <= door_d;
			stable_q   <= stable_d;
			boot_q     <= boot_d;
			alarm_q    <= alarm_d;
			alarm_el_q <= alarm_el_d;
			auth_q     <= auth_d;
			open_el_q  <= open_el_d;
			left_q     <= left_d;
			tone_el_q  <= tone_el_d;
			tone_hi_q  <= tone_hi_d;
			tone_q     <= tone_d;
			blink_el_q <= blink_el_d;
			blink_q    <= blink_d;
			red_q      <= red_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_free) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= accept;
			end
		end else if (accept) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_vld_q) begin
				out_q <= skid_q;
			end else if (accept) begin
				out_q <= res_d;
			end
		end else if (accept) begin
			skid_q <= res_d;
		end
	end

endmodule

/* hdl/diac_checker.sv */
// ----------------------------------------------------------------------------
// diac_checker
// Port-level checks on the result channel of the alarm controller.
// ----------------------------------------------------------------------------
module diac_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              result_valid,
	input logic              result_stall,
	input diac_pkg::result_t result
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result word changed while stalled");

	a_open: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.evt_opened |-> result.door_open && !result.evt_closed)
		else $error("open event without open door");

	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.evt_closed |-> !result.door_open && !result.left_open_active)
		else $error("close event with door still open or left-open running");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.evt_alarm_cleared |->
			!result.alarm_active && !result.door_open && result.red_led)
		else $error("alarm clear event with alarm still shown");

endmodule

bind door_intrusion_alarm_controller_core diac_checker u_diac_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
